FILE: hw/rtl/tvdgs_pkg.sv
// Shared types and constants of the total-variation gradient step block.
package tvdgs_pkg;

    localparam int PIX_W   = 24;
    localparam int RATIO_W = 18;
    localparam int GRAD_W  = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING   = 2'd2;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [9:0]  RST_FRAME_WIDTH = 10'd512;
    localparam logic [15:0] RST_STEP_SIZE   = 16'd410;
    localparam logic [31:0] RST_SMOOTHING   = 32'd16777;

    localparam logic signed [PIX_W+1:0] PIX_MAX = 26'sd8388607;
    localparam logic signed [PIX_W+1:0] PIX_MIN = -26'sd8388608;

    typedef logic signed [PIX_W-1:0]   pixel_t;
    typedef logic signed [RATIO_W-1:0] ratio_t;

endpackage

FILE: hw/rtl/tv_denoise_gradient_step_core.sv
// Top level of the streaming smoothed total-variation descent step.
//
// Pixels of a square frame (side frame_width, clamped to 2..MAX_WIDTH) arrive in raster
// order as signed Q12.12 requests with func low; each updated pixel x - alpha*grad leaves
// once the pixel one row below it has arrived, and flush requests (func high) push out the
// final row one pixel per flush after the whole frame is in. A flush before the frame is
// complete, and a pixel after it is complete, are dropped without a result. The last pixel
// of a frame carries last high and starts a new frame. A request that produces a result
// goes from acceptance to the output register through three window reads, three
// multiplier passes, the bit-serial square root and two divisions (the root and both
// divisions run on one shared compare-subtract unit), plus setup and rounding states.
// When the root is zero the divisions are skipped. A request that produces no result
// leaves the block idle. in_stall stays high while a request is in work; a finished
// result waits in the output register and the next request is accepted meanwhile.
// Writing frame_width restarts the frame; configuration writes are taken only while
// the block is idle.
module tv_denoise_gradient_step_core #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic signed [tvdgs_pkg::PIX_W-1:0]   pixel_value,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tvdgs_pkg::PIX_W-1:0]   updated_pixel,
    output logic                                 last,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tvdgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvdgs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WIN_DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW   = $clog2(WIN_DEPTH);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int NW   = $clog2(MAX_WIDTH + 1);
    localparam int FW   = (NW > 10) ? NW : 10;
    localparam int SW   = 50;  // dx^2 + dy^2 + eps
    localparam int RTW  = 25;  // root width
    localparam int RW   = 27;  // partial remainder width
    localparam int QW   = 17;  // ratio magnitude width
    localparam int DW   = 25;  // difference width
    localparam int PW   = 50;  // multiplier product width

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_X, ST_RD_R, ST_RD_D, ST_DIFF, ST_SQ_A, ST_SQ_B, ST_SQ_C,
        ST_ROOT, ST_DIV_SET, ST_DIV, ST_GRAD, ST_SCALE, ST_ROUND, ST_EMIT
    } state_t;

    state_t state_reg;

    logic [9:0]  frame_width_reg;
    logic [15:0] step_size_reg;
    logic [31:0] smoothing_reg;

    logic [AW-1:0] in_addr_reg, out_addr_reg;
    logic [CW-1:0] in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic          in_full_reg;
    tvdgs_pkg::ratio_t rprev_reg;

    tvdgs_pkg::pixel_t x_reg, xr_reg;
    tvdgs_pkg::ratio_t down_reg, rx_reg, ry_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0] prod_reg;
    logic [SW-1:0]  s_reg;
    logic [RW-1:0]  rem_reg;
    logic [RTW-1:0] root_reg;
    logic [QW-1:0]  qn_reg;
    logic [4:0]     cnt_reg;
    logic           sel_reg;
    logic signed [tvdgs_pkg::GRAD_W-1:0] grad_reg;
    logic signed [21:0] step_reg;

    logic                      out_valid_reg, last_reg;
    tvdgs_pkg::pixel_t         updated_pixel_reg;

    // Frame side, clamped.
    logic [FW-1:0] fw_ext;
    logic [NW-1:0] side_n, side_m1;
    always_comb
    begin
        fw_ext = FW'(frame_width_reg);
        if (fw_ext < FW'(2))
        begin
            side_n = NW'(2);
        end
        else if (fw_ext > FW'(MAX_WIDTH))
        begin
            side_n = NW'(MAX_WIDTH);
        end
        else
        begin
            side_n = NW'(fw_ext);
        end
        side_m1 = side_n - NW'(1);
    end

    logic in_col_end, in_row_end, out_col_end, out_row_end, out_last;
    assign in_col_end  = (NW'(in_col_reg) == side_m1);
    assign in_row_end  = (NW'(in_row_reg) == side_m1);
    assign out_col_end = (NW'(out_col_reg) == side_m1);
    assign out_row_end = (NW'(out_row_reg) == side_m1);
    assign out_last    = out_col_end && out_row_end;

    // Neighbor addresses in the circular window.
    logic [AW:0]   sum_p1, sum_pn;
    logic [AW-1:0] addr_p1, addr_pn, in_addr_inc;
    always_comb
    begin
        sum_p1 = (AW+1)'(out_addr_reg) + (AW+1)'(1);
        sum_pn = (AW+1)'(out_addr_reg) + (AW+1)'(side_n);
        addr_p1 = (sum_p1 >= (AW+1)'(WIN_DEPTH)) ? AW'(sum_p1 - (AW+1)'(WIN_DEPTH))
                                                 : AW'(sum_p1);
        addr_pn = (sum_pn >= (AW+1)'(WIN_DEPTH)) ? AW'(sum_pn - (AW+1)'(WIN_DEPTH))
                                                 : AW'(sum_pn);
        in_addr_inc = (in_addr_reg == AW'(WIN_DEPTH - 1)) ? '0 : in_addr_reg + AW'(1);
    end

    // Handshakes.
    logic in_acc, cfg_acc, out_free;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;

    // Window and ratio-row memories.
    localparam int RATIO_W_LOCAL = tvdgs_pkg::RATIO_W;
    logic                   win_we;
    logic [AW-1:0]          win_raddr;
    logic [tvdgs_pkg::PIX_W-1:0] win_rdata;
    logic                   down_we;
    logic [RATIO_W_LOCAL-1:0] down_rdata;

    assign win_we  = in_acc && (func == tvdgs_pkg::FUNC_PIXEL) && !in_full_reg;
    assign down_we = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        case (state_reg)
            ST_RD_R: win_raddr = addr_p1;
            ST_RD_D: win_raddr = addr_pn;
            default: win_raddr = out_addr_reg;
        endcase
    end

    tvdgs_ram #(
        .WIDTH(tvdgs_pkg::PIX_W),
        .DEPTH(WIN_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (in_addr_reg),
        .wdata (pixel_value),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    tvdgs_ram #(
        .WIDTH(tvdgs_pkg::RATIO_W),
        .DEPTH(MAX_WIDTH)
    ) u_down_ram (
        .clk   (clk),
        .we    (down_we),
        .waddr (out_col_reg),
        .wdata (ry_reg),
        .raddr (out_col_reg),
        .rdata (down_rdata)
    );

    // Shared multiplier.
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    always_comb
    begin
        case (state_reg)
            ST_SQ_B:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            ST_SCALE:
            begin
                mul_a = DW'(grad_reg);
                mul_b = $signed({9'b0, step_size_reg});
            end
            default:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Shared compare-subtract unit for the root and the divisions.
    logic [28:0] cs_a, cs_b;
    logic [29:0] cs_diff;
    logic        cs_ok;
    always_comb
    begin
        if (state_reg == ST_ROOT)
        begin
            cs_a = {rem_reg, s_reg[SW-1 -: 2]};
            cs_b = 29'({root_reg, 2'b01});
        end
        else
        begin
            cs_a = 29'({rem_reg[RW-2:0], qn_reg[QW-1]});
            cs_b = 29'(root_reg);
        end
        cs_diff = {1'b0, cs_a} - {1'b0, cs_b};
        cs_ok   = !cs_diff[29];
    end

    // Differences, division setup, ratio and output arithmetic.
    localparam int PIX_W_L = tvdgs_pkg::PIX_W;
    logic signed [DW-1:0] dx_c, dy_c, d_sel;
    logic [DW-1:0]        d_mag;
    logic [40:0]          div_num;
    logic [QW-1:0]        q_next;
    tvdgs_pkg::ratio_t    ratio_c;
    logic signed [tvdgs_pkg::GRAD_W-1:0] grad_c;
    logic [PW-1:0]        p_mag;
    logic [PW-1:0]        p_rnd;
    logic [20:0]          q_step;
    logic signed [PIX_W_L+1:0] y_c;
    tvdgs_pkg::pixel_t    y_sat;

    always_comb
    begin
        dx_c = (NW'(out_col_reg) < side_m1) ? (DW'(xr_reg) - DW'(x_reg)) : '0;
        dy_c = (NW'(out_row_reg) < side_m1) ? (DW'($signed(win_rdata)) - DW'(x_reg)) : '0;

        d_sel   = sel_reg ? dy_reg : dx_reg;
        d_mag   = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
        div_num = 41'({d_mag, 16'd0}) + 41'(root_reg >> 1);

        q_next  = {qn_reg[QW-2:0], cs_ok};
        ratio_c = d_sel[DW-1] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});

        grad_c = -tvdgs_pkg::GRAD_W'(rx_reg) - tvdgs_pkg::GRAD_W'(ry_reg);
        if (out_col_reg != '0)
        begin
            grad_c = grad_c + tvdgs_pkg::GRAD_W'(rprev_reg);
        end
        if (out_row_reg != '0)
        begin
            grad_c = grad_c + tvdgs_pkg::GRAD_W'(down_reg);
        end

        p_mag  = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
        p_rnd  = p_mag + PW'(32768);
        q_step = p_rnd[36:16];

        y_c = (PIX_W_L+2)'(x_reg) - (PIX_W_L+2)'(step_reg);
        if (y_c > tvdgs_pkg::PIX_MAX)
        begin
            y_sat = tvdgs_pkg::pixel_t'(tvdgs_pkg::PIX_MAX);
        end
        else if (y_c < tvdgs_pkg::PIX_MIN)
        begin
            y_sat = tvdgs_pkg::pixel_t'(tvdgs_pkg::PIX_MIN);
        end
        else
        begin
            y_sat = tvdgs_pkg::pixel_t'(y_c);
        end
    end

    // Sequencer, state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_width_reg <= tvdgs_pkg::RST_FRAME_WIDTH;
            step_size_reg   <= tvdgs_pkg::RST_STEP_SIZE;
            smoothing_reg   <= tvdgs_pkg::RST_SMOOTHING;
            in_addr_reg     <= '0;
            out_addr_reg    <= '0;
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            in_full_reg     <= 1'b0;
            rprev_reg       <= '0;
            sel_reg         <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_acc)
                    begin
                        case (cfg_index)
                            tvdgs_pkg::CFG_FRAME_WIDTH:
                            begin
                                frame_width_reg <= cfg_data[9:0];
                                in_addr_reg  <= '0;
                                out_addr_reg <= '0;
                                in_col_reg   <= '0;
                                in_row_reg   <= '0;
                                out_col_reg  <= '0;
                                out_row_reg  <= '0;
                                in_full_reg  <= 1'b0;
                                rprev_reg    <= '0;
                            end
                            tvdgs_pkg::CFG_STEP_SIZE: step_size_reg <= cfg_data[15:0];
                            tvdgs_pkg::CFG_SMOOTHING: smoothing_reg <= cfg_data;
                            default: ;
                        endcase
                    end
                    else if (in_acc)
                    begin
                        if (func == tvdgs_pkg::FUNC_PIXEL)
                        begin
                            if (!in_full_reg)
                            begin
                                in_addr_reg <= in_addr_inc;
                                if (in_col_end)
                                begin
                                    in_col_reg <= '0;
                                    if (in_row_end)
                                    begin
                                        in_full_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        in_row_reg <= in_row_reg + CW'(1);
                                    end
                                end
                                else
                                begin
                                    in_col_reg <= in_col_reg + CW'(1);
                                end
                                if (in_row_reg != '0)
                                begin
                                    state_reg <= ST_RD_X;
                                end
                            end
                        end
                        else if (in_full_reg)
                        begin
                            state_reg <= ST_RD_X;
                        end
                    end
                end
                ST_RD_X: state_reg <= ST_RD_R;
                ST_RD_R:
                begin
                    x_reg     <= win_rdata;
                    down_reg  <= down_rdata;
                    state_reg <= ST_RD_D;
                end
                ST_RD_D:
                begin
                    xr_reg    <= win_rdata;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    dx_reg    <= dx_c;
                    dy_reg    <= dy_c;
                    state_reg <= ST_SQ_A;
                end
                ST_SQ_A:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ_B;
                end
                ST_SQ_B:
                begin
                    s_reg     <= SW'(prod_reg) + SW'(smoothing_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ_C;
                end
                ST_SQ_C:
                begin
                    s_reg     <= s_reg + SW'(prod_reg);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= 5'(RTW - 1);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    s_reg    <= {s_reg[SW-3:0], 2'b00};
                    root_reg <= {root_reg[RTW-2:0], cs_ok};
                    rem_reg  <= cs_ok ? RW'(cs_diff) : RW'(cs_a);
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == '0)
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= ST_DIV_SET;
                    end
                end
                ST_DIV_SET:
                begin
                    if (root_reg == '0)
                    begin
                        // Zero root: both ratios are zero.
                        rx_reg    <= '0;
                        ry_reg    <= '0;
                        state_reg <= ST_GRAD;
                    end
                    else
                    begin
                        rem_reg   <= RW'(div_num[40:QW]);
                        qn_reg    <= div_num[QW-1:0];
                        cnt_reg   <= 5'(QW - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    qn_reg  <= q_next;
                    rem_reg <= cs_ok ? RW'(cs_diff) : RW'(cs_a);
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0)
                    begin
                        if (!sel_reg)
                        begin
                            rx_reg    <= ratio_c;
                            sel_reg   <= 1'b1;
                            state_reg <= ST_DIV_SET;
                        end
                        else
                        begin
                            ry_reg    <= ratio_c;
                            state_reg <= ST_GRAD;
                        end
                    end
                end
                ST_GRAD:
                begin
                    grad_reg  <= grad_c;
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    step_reg  <= prod_reg[PW-1] ? -$signed({1'b0, q_step})
                                                : $signed({1'b0, q_step});
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        updated_pixel_reg <= y_sat;
                        last_reg          <= out_last;
                        state_reg         <= ST_IDLE;
                        if (out_last)
                        begin
                            // Frame end: everything returns to the first pixel.
                            in_addr_reg  <= '0;
                            out_addr_reg <= '0;
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            in_full_reg  <= 1'b0;
                            rprev_reg    <= '0;
                        end
                        else
                        begin
                            rprev_reg    <= rx_reg;
                            out_addr_reg <= addr_p1;
                            if (out_col_end)
                            begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + CW'(1);
                            end
                            else
                            begin
                                out_col_reg <= out_col_reg + CW'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign updated_pixel = updated_pixel_reg;
    assign last          = last_reg;

    // A division never starts against a zero root.
    a_div_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (root_reg != '0))
        else $error("division running with zero root");

    // The output position never leaves the frame.
    a_out_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (NW'(out_col_reg) <= side_m1) && (NW'(out_row_reg) <= side_m1))
        else $error("output position outside the frame");

    // A pixel of the first row produces no result and leaves the block idle.
    a_first_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (func == tvdgs_pkg::FUNC_PIXEL) && !in_full_reg && (in_row_reg == '0))
        |=> (state_reg == ST_IDLE))
        else $error("first-row pixel started a computation");

endmodule

FILE: hw/rtl/tvdgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tvdgs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1026
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: dv/tvdgs_checker.sv
// Checker that predicts and compares the results of the total-variation step block.
`timescale 1ns / 100ps

module tvdgs_checker #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             func,
    input  tvdgs_pkg::pixel_t                pixel_value,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  tvdgs_pkg::pixel_t                updated_pixel,
    input  logic                             last,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tvdgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvdgs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               results_seen
);

    localparam int WIN_DEPTH = 2 * MAX_WIDTH + 2;

    typedef struct packed {
        tvdgs_pkg::pixel_t pix;
        logic              last;
    } step_result_t;

    logic [9:0]  side_reg;
    logic [15:0] alpha_reg;
    logic [31:0] eps_reg;

    longint       pix_window [WIN_DEPTH];
    longint       ratio_above [MAX_WIDTH];
    longint       ratio_left;
    int           in_pos;
    int           out_pos;
    step_result_t expected_pixels [$];

    function automatic longint div_near(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic int side_used();
        int n;
        n = int'(side_reg);
        if (n < 2) n = 2;
        if (n > MAX_WIDTH) n = MAX_WIDTH;
        return n;
    endfunction

    function automatic void restart_frame();
        in_pos = 0;
        out_pos = 0;
        ratio_left = 0;
    endfunction

    // Computes the descent step for the pixel at the output position and queues it.
    function automatic void predict_update();
        int n;
        int p;
        int i;
        int j;
        longint x;
        longint dx;
        longint dy;
        longint g;
        longint rx;
        longint ry;
        longint grad;
        longint y;
        step_result_t r;
        n = side_used();
        p = out_pos;
        i = p / n;
        j = p % n;
        x = pix_window[p % WIN_DEPTH];
        dx = 0;
        dy = 0;
        if (j < n - 1) dx = pix_window[(p + 1) % WIN_DEPTH] - x;
        if (i < n - 1) dy = pix_window[(p + n) % WIN_DEPTH] - x;
        g = floor_sqrt(longint'(dx * dx + dy * dy) + longint'(eps_reg));
        rx = (g == 0) ? 0 : div_near(dx * 65536, g);
        ry = (g == 0) ? 0 : div_near(dy * 65536, g);
        grad = -rx - ry;
        if (j > 0) grad += ratio_left;
        if (i > 0) grad += ratio_above[j];
        y = x - div_near(grad * longint'(alpha_reg), 65536);
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        ratio_left = rx;
        ratio_above[j] = ry;
        out_pos = p + 1;
        r.pix = tvdgs_pkg::pixel_t'(y);
        r.last = (p == n * n - 1);
        expected_pixels.push_back(r);
        if (r.last) restart_frame();
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        int n;
        if (!rst_n)
        begin
            side_reg = tvdgs_pkg::RST_FRAME_WIDTH;
            alpha_reg = tvdgs_pkg::RST_STEP_SIZE;
            eps_reg = tvdgs_pkg::RST_SMOOTHING;
            restart_frame();
            expected_pixels.delete();
            fail_count = 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tvdgs_pkg::CFG_FRAME_WIDTH:
                    begin
                        side_reg = cfg_data[9:0];
                        restart_frame();
                    end
                    tvdgs_pkg::CFG_STEP_SIZE: alpha_reg = cfg_data[15:0];
                    tvdgs_pkg::CFG_SMOOTHING: eps_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                n = side_used();
                if (func == tvdgs_pkg::FUNC_PIXEL)
                begin
                    if (in_pos < n * n)
                    begin
                        pix_window[in_pos % WIN_DEPTH] = longint'(pixel_value);
                        in_pos++;
                        if (in_pos - 1 >= n) predict_update();
                    end
                end
                else if (in_pos >= n * n && out_pos < n * n)
                begin
                    predict_update();
                end
            end
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("result with nothing expected", updated_pixel, 0);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (updated_pixel !== want.pix)
                        report_mismatch("updated_pixel", updated_pixel, want.pix);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

FILE: dv/tb.sv
// Top of the testbench: stimulus, configuration phases and verdict for the gradient step block.
`timescale 1ns / 100ps

module tb;

    // Register index that the block does not decode.
    localparam logic [tvdgs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic                             func;
    tvdgs_pkg::pixel_t                pixel_value;
    logic                             out_valid;
    logic                             out_stall;
    tvdgs_pkg::pixel_t                updated_pixel;
    logic                             last;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tvdgs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tvdgs_pkg::CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int results_seen;

    // Counts of what was sent, used only to stop the stimulus and for the summary.
    int requests_sent;
    int frames_sent;
    int widths_seen;
    bit idle_on;

    tv_denoise_gradient_step_core #(.MAX_WIDTH(512)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .pixel_value(pixel_value),
        .out_valid(out_valid), .out_stall(out_stall), .updated_pixel(updated_pixel),
        .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // The checker sits beside the block and sees exactly the same pins.
    tvdgs_checker #(.MAX_WIDTH(512)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .pixel_value(pixel_value),
        .out_valid(out_valid), .out_stall(out_stall), .updated_pixel(updated_pixel),
        .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result-side back-pressure comes in random bursts while idling is enabled.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Sends one request and returns at the edge that accepted it. Valid stays high
    // afterwards so that back-to-back requests follow without a gap.
    task automatic send_request(input logic f, input tvdgs_pkg::pixel_t v);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        pixel_value <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
    endtask

    // Waits until every predicted result has come out, then lets the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Register writes are only issued from an idle block.
    task automatic write_reg(input logic [tvdgs_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [tvdgs_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == tvdgs_pkg::CFG_FRAME_WIDTH) widths_seen++;
    endtask

    // Pixel content: full-range noise, small variations around a base, flat areas or rails.
    function automatic tvdgs_pkg::pixel_t pick_pixel(input int style,
                                                     input tvdgs_pkg::pixel_t base);
        case (style)
            0: return tvdgs_pkg::pixel_t'($urandom);
            1: return base + tvdgs_pkg::pixel_t'($urandom_range(0, 2048))
                      - tvdgs_pkg::pixel_t'(1024);
            2: return base;
            default: return ($urandom_range(0, 1) == 1) ? tvdgs_pkg::pixel_t'(24'h7FFFFF)
                                                        : tvdgs_pkg::pixel_t'(24'h800000);
        endcase
    endfunction

    // One well-formed frame of side n, with optional ignored noise: early flushes among the
    // pixels of the frame and a surplus pixel once the frame is complete.
    task automatic send_frame(input int n, input int style, input bit noisy);
        tvdgs_pkg::pixel_t base;
        int k;
        base = tvdgs_pkg::pixel_t'($urandom);
        for (k = 0; k < n * n; k++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_request(tvdgs_pkg::FUNC_FLUSH, tvdgs_pkg::pixel_t'($urandom));
            send_request(tvdgs_pkg::FUNC_PIXEL, pick_pixel(style, base));
        end
        if (noisy && $urandom_range(0, 2) == 0)
            send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'($urandom));
        for (k = 0; k < n; k++)
            send_request(tvdgs_pkg::FUNC_FLUSH, tvdgs_pkg::pixel_t'($urandom));
        frames_sent++;
    endtask

    initial
    begin
        int n;
        int nframes;
        int f;
        logic [31:0] eps_pick;
        logic [15:0] alpha_pick;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= tvdgs_pkg::FUNC_PIXEL;
        pixel_value <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= tvdgs_pkg::CFG_FRAME_WIDTH;
        cfg_data <= '0;
        requests_sent = 0;
        frames_sent = 0;
        widths_seen = 0;
        idle_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A flat frame with no smoothing makes the square root zero;
        // the flush in the middle comes too early and the pixel after the frame is
        // surplus, so both must be dropped.
        write_reg(tvdgs_pkg::CFG_FRAME_WIDTH, 32'd2);
        write_reg(tvdgs_pkg::CFG_STEP_SIZE, 32'd65535);
        write_reg(tvdgs_pkg::CFG_SMOOTHING, 32'd0);
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(0));
        send_request(tvdgs_pkg::FUNC_FLUSH, tvdgs_pkg::pixel_t'(0));
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(0));
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(0));
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(0));
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(24'h123456));
        send_request(tvdgs_pkg::FUNC_FLUSH, tvdgs_pkg::pixel_t'(0));
        send_request(tvdgs_pkg::FUNC_FLUSH, tvdgs_pkg::pixel_t'(0));
        wait_idle();

        // Rails with the largest step: a frame whose pixels sit at both ends of the range.
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(24'h7FFFFF));
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(24'h800000));
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(24'h800000));
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'(24'h7FFFFF));
        send_request(tvdgs_pkg::FUNC_FLUSH, tvdgs_pkg::pixel_t'(24'hFFFFFF));
        send_request(tvdgs_pkg::FUNC_FLUSH, tvdgs_pkg::pixel_t'(0));
        wait_idle();

        // A width write in the middle of a frame throws the partial frame away.
        write_reg(tvdgs_pkg::CFG_FRAME_WIDTH, 32'd3);
        write_reg(tvdgs_pkg::CFG_SMOOTHING, 32'hFFFFFFFF);
        for (f = 0; f < 4; f++)
            send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'($urandom));
        wait_idle();
        write_reg(tvdgs_pkg::CFG_FRAME_WIDTH, 32'd1023);
        for (f = 0; f < 3; f++)
            send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'($urandom));
        wait_idle();
        write_reg(tvdgs_pkg::CFG_FRAME_WIDTH, 32'd512);
        send_request(tvdgs_pkg::FUNC_PIXEL, tvdgs_pkg::pixel_t'($urandom));
        wait_idle();

        // Widths below the minimum clamp to two; an unused register index is ignored.
        write_reg(tvdgs_pkg::CFG_FRAME_WIDTH, 32'd0);
        write_reg(tvdgs_pkg::CFG_STEP_SIZE, 32'd0);
        write_reg(CFG_UNUSED_INDEX, 32'hFFFFFFFF);
        send_frame(2, 0, 1'b0);
        wait_idle();
        write_reg(tvdgs_pkg::CFG_FRAME_WIDTH, 32'd1);
        write_reg(tvdgs_pkg::CFG_STEP_SIZE, 32'd410);
        write_reg(tvdgs_pkg::CFG_SMOOTHING, 32'd1);
        send_frame(2, 3, 1'b0);
        wait_idle();

        // Random phases: small frames half of the time, otherwise medium or larger ones, each
        // phase with a fresh setting of all registers. Idling stops for the last stretch of the run.
        while (requests_sent < 1200)
        begin
            if (requests_sent > 950) idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: n = $urandom_range(2, 4);
                4, 5, 6, 7: n = $urandom_range(5, 9);
                8: n = $urandom_range(10, 16);
                default: n = 2;
            endcase
            case ($urandom_range(0, 4))
                0: alpha_pick = 16'd0;
                1: alpha_pick = 16'hFFFF;
                2: alpha_pick = 16'd410;
                default: alpha_pick = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: eps_pick = 32'd1;
                1: eps_pick = 32'hFFFFFFFF;
                2: eps_pick = 32'd16777;
                3: eps_pick = 32'($urandom_range(0, 65535));
                default: eps_pick = $urandom;
            endcase
            write_reg(tvdgs_pkg::CFG_FRAME_WIDTH, 32'(n));
            write_reg(tvdgs_pkg::CFG_STEP_SIZE, 32'(alpha_pick));
            write_reg(tvdgs_pkg::CFG_SMOOTHING, eps_pick);
            nframes = (n > 9) ? 1 : $urandom_range(1, 3);
            for (f = 0; f < nframes; f++)
                send_frame(n, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
            // The hold-off until everything is out doubles as the idle point for the
            // next register writes.
            wait_idle();
        end

        wait_idle();
        $display("Sent %0d requests in %0d frames over %0d width settings;", requests_sent,
                 frames_sent, widths_seen);
        $display("checked %0d updated pixels with saturation, flat and noise cases.",
                 results_seen);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #24000000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tvdgs_pkg.sv
hw/rtl/tvdgs_ram.sv
hw/rtl/tv_denoise_gradient_step_core.sv
dv/tvdgs_checker.sv
dv/tb.sv
